FILE: rtl/core/mcns_pkg.sv
// Shared types and constants of the minimum-cost node selector.
package mcns_pkg;

    localparam int COST_W     = 48;
    localparam int NODE_IDX_W = 6;
    localparam int SLOT_IDX_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_NODES        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_READ_WEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REMOTE_READ_WEIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REMOTE_WRITE_WEIGHT = 2'd3;

    // Operation codes of an input item.
    localparam logic OP_SLOT_WRITE = 1'b0;
    localparam logic OP_QUERY      = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  node;
        logic [2:0]  slot;
        logic [7:0]  table_id;
        logic [31:0] key_lower;
        logic [31:0] key_upper;
        logic        slot_valid;
        logic        is_write;
        logic        last_query;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        best_node;
        logic [COST_W-1:0] best_cost;
        logic              cost_saturated;
    } out_item_t;

    // Broadcast from the sequencer to every node cell.
    typedef struct packed {
        logic                  wr_en;
        logic [3:0]            wr_node;
        logic [2:0]            wr_slot;
        logic [7:0]            wr_table;
        logic [31:0]           wr_lower;
        logic [31:0]           wr_upper;
        logic                  wr_in_use;
        logic                  start;
        logic                  rd_en;
        logic [SLOT_IDX_W-1:0] rd_addr;
        logic [7:0]            q_table;
        logic [31:0]           q_lower;
        logic [31:0]           q_upper;
        logic [32:0]           q_size;
        logic                  step_rem;
        logic                  step_mul_a;
        logic                  step_mul_b;
        logic                  step_sum;
        logic                  step_acc;
        logic                  clear;
        logic [15:0]           weight_a;
        logic [15:0]           weight_b;
        logic [NODE_IDX_W:0]   eff_nodes;
    } ctrl_t;

    // Running minimum handed from cell to cell.
    typedef struct packed {
        logic                  found;
        logic [NODE_IDX_W-1:0] node;
        logic [COST_W-1:0]     cost;
        logic                  sat;
    } token_t;

endpackage

FILE: rtl/core/mcns_ram.sv
// Generic single-port-write, registered-read RAM.
module mcns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/mcns_node_cell.sv
// One node cell: range slots, overlap scan, cost accumulator and one link of the minimum chain.
module mcns_node_cell #(
    parameter int NODE_ID         = 0,
    parameter int RANGES_PER_NODE = 8,
    parameter int KEY_BITS        = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mcns_pkg::ctrl_t     ctrl,
    input  mcns_pkg::token_t    tok_in,
    output mcns_pkg::token_t    tok_out
);

    localparam int AW    = (RANGES_PER_NODE > 1) ? $clog2(RANGES_PER_NODE) : 1;
    localparam int SW    = KEY_BITS + 1;
    localparam int LW    = KEY_BITS + $clog2(RANGES_PER_NODE) + 1;
    localparam int PW    = LW + 16;
    localparam int SUM_W = (PW + 1 > mcns_pkg::COST_W + 1) ? PW + 1 : mcns_pkg::COST_W + 1;
    localparam int RW    = 2 * KEY_BITS + 8;

    logic                   wr_hit;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [RW-1:0]          rd_data;
    logic [RANGES_PER_NODE-1:0] in_use_reg;
    logic                   in_use_q_reg;

    logic [KEY_BITS-1:0]    slot_lo, slot_hi, q_lo, q_hi;
    logic [7:0]             slot_tab;
    logic [KEY_BITS-1:0]    lo_next, hi_next, lo_reg, hi_reg;
    logic                   hit_next, hit_reg;
    logic                   v1_reg, v2_reg, v3_reg;
    logic [SW-1:0]          ov_next, ov_reg;
    logic [LW-1:0]          local_reg;
    logic [LW-1:0]          size_ext;
    logic [SW-1:0]          remote_next, remote_reg;
    logic [LW-1:0]          mul_a;
    logic [15:0]            mul_w;
    logic [PW-1:0]          prod_next, prod_reg, prod_a_reg;
    logic [SUM_W-1:0]       sum;
    logic                   sum_over;
    logic [mcns_pkg::COST_W-1:0] cost_reg, acc_reg;
    logic                   csat_reg, sat_reg;
    logic [mcns_pkg::COST_W:0]   acc_sum;
    logic                   active;
    logic                   take_own;
    mcns_pkg::token_t       own_tok, tok_reg;

    // Slot store: lower key, upper key and table id of every range slot.
    assign wr_hit  = ctrl.wr_en && (int'(ctrl.wr_node) == NODE_ID)
                     && (int'(ctrl.wr_slot) < RANGES_PER_NODE);
    assign wr_addr = AW'(ctrl.wr_slot);
    assign rd_addr = ctrl.rd_addr[AW-1:0];

    mcns_ram #(
        .WIDTH (RW),
        .DEPTH (RANGES_PER_NODE)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_hit),
        .wr_addr (wr_addr),
        .wr_data ({KEY_BITS'(ctrl.wr_lower), KEY_BITS'(ctrl.wr_upper), ctrl.wr_table}),
        .rd_en   (ctrl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else if (wr_hit) begin
            in_use_reg[wr_addr] <= ctrl.wr_in_use;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            in_use_q_reg <= in_use_reg[rd_addr];
        end
    end

    // Overlap of the slot read last cycle with the query range.
    assign slot_lo  = rd_data[RW-1 -: KEY_BITS];
    assign slot_hi  = rd_data[8 +: KEY_BITS];
    assign slot_tab = rd_data[7:0];
    assign q_lo     = KEY_BITS'(ctrl.q_lower);
    assign q_hi     = KEY_BITS'(ctrl.q_upper);

    assign lo_next  = (slot_lo > q_lo) ? slot_lo : q_lo;
    assign hi_next  = (slot_hi < q_hi) ? slot_hi : q_hi;
    assign hit_next = in_use_q_reg && (slot_tab == ctrl.q_table);

    assign ov_next = (hit_reg && (hi_reg >= lo_reg))
                     ? ({1'b0, hi_reg} - {1'b0, lo_reg} + SW'(1)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= ctrl.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        hit_reg <= hit_next;
        ov_reg  <= ov_next;
        if (ctrl.start) begin
            local_reg <= '0;
        end else if (v3_reg) begin
            local_reg <= local_reg + LW'(ov_reg);
        end
    end

    // Cost of the query: one shared multiplier used for both terms.
    assign size_ext    = LW'(SW'(ctrl.q_size));
    assign remote_next = (local_reg >= size_ext) ? '0 : SW'(size_ext - local_reg);
    assign mul_a       = ctrl.step_mul_a ? local_reg : LW'(remote_reg);
    assign mul_w       = ctrl.step_mul_a ? ctrl.weight_a : ctrl.weight_b;
    assign prod_next   = PW'(mul_a) * PW'(mul_w);
    assign sum         = SUM_W'(prod_a_reg) + SUM_W'(prod_reg);
    assign sum_over    = sum > SUM_W'(mcns_pkg::COST_MAX);

    always_ff @(posedge aclk) begin
        if (ctrl.step_rem) begin
            remote_reg <= remote_next;
        end
        if (ctrl.step_mul_a || ctrl.step_mul_b) begin
            prod_reg <= prod_next;
        end
        if (ctrl.step_mul_b) begin
            prod_a_reg <= prod_reg;
        end
        if (ctrl.step_sum) begin
            cost_reg <= sum_over ? mcns_pkg::COST_MAX : sum[mcns_pkg::COST_W-1:0];
            csat_reg <= sum_over;
        end
    end

    // Saturating accumulator of this node.
    assign active  = NODE_ID < int'(ctrl.eff_nodes);
    assign acc_sum = {1'b0, acc_reg} + {1'b0, cost_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (ctrl.clear) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (ctrl.step_acc && active) begin
            if (acc_sum[mcns_pkg::COST_W]) begin
                acc_reg <= mcns_pkg::COST_MAX;
                sat_reg <= 1'b1;
            end else begin
                acc_reg <= acc_sum[mcns_pkg::COST_W-1:0];
                sat_reg <= sat_reg | csat_reg;
            end
        end
    end

    // Minimum chain: strict compare keeps the lower node id on a tie.
    always_comb begin
        own_tok.found = 1'b1;
        own_tok.node  = mcns_pkg::NODE_IDX_W'(NODE_ID);
        own_tok.cost  = acc_reg;
        own_tok.sat   = sat_reg;
    end

    assign take_own = active && (!tok_in.found || (acc_reg < tok_in.cost));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= take_own ? own_tok : tok_in;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: rtl/core/min_cost_node_selector_core.sv
// Top level of the minimum-cost node selector: sequencer, registers and the row of node cells.
//
//   Channel  Ports                                   Direction  Carries
//   input    s_valid, s_ready, s_data                in         slot writes and queries
//   result   m_valid, m_ready, m_data                out        chosen node, cost, flag
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  in      weight and node count
//
// A slot write completes with its input transfer. A query reads the slot memory once per
// range slot in every node cell, drains the overlap pipeline, and runs five steps on the
// shared per-cell multiplier and saturating adders. A query marked last then lets the
// running minimum walk down the chain of cells before the result is loaded.
// Reset clears the in-use bits, the node costs and the control state; slot contents are
// unknown until written. The result register frees the input side: a finished result can
// wait for m_ready while the next items are taken, and only a second result stalls.
module min_cost_node_selector_core #(
    parameter int MAX_NODES       = 16,
    parameter int RANGES_PER_NODE = 8,
    parameter int KEY_BITS        = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mcns_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mcns_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcns_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW    = KEY_BITS + 1;
    localparam int CNT_W = $clog2(RANGES_PER_NODE + MAX_NODES + 8) + 1;

    // Steps of the cost phase.
    localparam logic [CNT_W-1:0] STEP_REM   = CNT_W'(0);
    localparam logic [CNT_W-1:0] STEP_MUL_A = CNT_W'(1);
    localparam logic [CNT_W-1:0] STEP_MUL_B = CNT_W'(2);
    localparam logic [CNT_W-1:0] STEP_SUM   = CNT_W'(3);
    localparam logic [CNT_W-1:0] STEP_ACC   = CNT_W'(4);
    localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(2);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_COST   = 5'b01000,
        ST_SELECT = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // Configuration registers. The port never stalls; a write takes effect at once, so registers
    // are to be written only while no item is in flight; the block itself does not enforce this.
    logic [4:0]             active_nodes_reg;
    logic [15:0]            local_read_weight_reg;
    logic [15:0]            remote_read_weight_reg;
    logic [15:0]            remote_write_weight_reg;
    logic [mcns_pkg::NODE_IDX_W:0] eff_nodes;

    // Query held while it is worked on.
    logic [7:0]             q_table_reg;
    logic [KEY_BITS-1:0]    q_lower_reg, q_upper_reg;
    logic                   q_is_write_reg, q_last_reg;
    logic [SW-1:0]          size_reg;

    logic                   in_xfer;
    logic                   query_xfer;
    logic                   out_free;
    logic                   load_out;
    logic                   m_valid_reg;
    mcns_pkg::out_item_t    m_data_reg;

    mcns_pkg::ctrl_t        ctrl;
    mcns_pkg::token_t       tok [MAX_NODES+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_nodes_reg        <= 5'd16;
            local_read_weight_reg   <= 16'd1;
            remote_read_weight_reg  <= 16'd10;
            remote_write_weight_reg <= 16'd20;
        end else if (cfg_valid) begin
            case (cfg_index)
                mcns_pkg::REG_ACTIVE_NODES:        active_nodes_reg        <= cfg_data[4:0];
                mcns_pkg::REG_LOCAL_READ_WEIGHT:   local_read_weight_reg   <= cfg_data;
                mcns_pkg::REG_REMOTE_READ_WEIGHT:  remote_read_weight_reg  <= cfg_data;
                mcns_pkg::REG_REMOTE_WRITE_WEIGHT: remote_write_weight_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A count of zero acts as one node; a count above the cell row acts as the whole row.
    always_comb begin
        if (active_nodes_reg == 5'd0) begin
            eff_nodes = (mcns_pkg::NODE_IDX_W + 1)'(1);
        end else if (int'(active_nodes_reg) > MAX_NODES) begin
            eff_nodes = (mcns_pkg::NODE_IDX_W + 1)'(MAX_NODES);
        end else begin
            eff_nodes = (mcns_pkg::NODE_IDX_W + 1)'(active_nodes_reg);
        end
    end

    // Input side: items are taken only between queries.
    assign s_ready    = (state_reg == ST_IDLE);
    assign in_xfer    = s_valid && s_ready;
    assign query_xfer = in_xfer && (s_data.operation == mcns_pkg::OP_QUERY);

    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_SELECT) && (cnt_reg == CNT_W'(MAX_NODES)) && out_free;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (query_xfer) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CNT_W'(RANGES_PER_NODE - 1)) begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (cnt_reg == DRAIN_LAST) begin
                    state_next = ST_COST;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_COST: begin
                if (cnt_reg == STEP_ACC) begin
                    state_next = q_last_reg ? ST_SELECT : ST_IDLE;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SELECT: begin
                if (cnt_reg != CNT_W'(MAX_NODES)) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end else if (out_free) begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Query registers; keys are taken modulo the key width. The size of an empty range is zero.
    always_ff @(posedge aclk) begin
        if (query_xfer) begin
            q_table_reg    <= s_data.table_id;
            q_lower_reg    <= KEY_BITS'(s_data.key_lower);
            q_upper_reg    <= KEY_BITS'(s_data.key_upper);
            q_is_write_reg <= s_data.is_write;
            q_last_reg     <= s_data.last_query;
        end
        if (state_reg == ST_SCAN) begin
            size_reg <= (q_upper_reg < q_lower_reg) ? '0
                        : ({1'b0, q_upper_reg} - {1'b0, q_lower_reg} + SW'(1));
        end
    end

    // Broadcast control for the cell row. Slot writes go straight from the input transfer.
    always_comb begin
        ctrl            = '0;
        ctrl.wr_en      = in_xfer && (s_data.operation == mcns_pkg::OP_SLOT_WRITE);
        ctrl.wr_node    = s_data.node;
        ctrl.wr_slot    = s_data.slot;
        ctrl.wr_table   = s_data.table_id;
        ctrl.wr_lower   = s_data.key_lower;
        ctrl.wr_upper   = s_data.key_upper;
        ctrl.wr_in_use  = s_data.slot_valid;
        ctrl.start      = query_xfer;
        ctrl.rd_en      = (state_reg == ST_SCAN);
        ctrl.rd_addr    = mcns_pkg::SLOT_IDX_W'(cnt_reg);
        ctrl.q_table    = q_table_reg;
        ctrl.q_lower    = 32'(q_lower_reg);
        ctrl.q_upper    = 32'(q_upper_reg);
        ctrl.q_size     = 33'(size_reg);
        ctrl.step_rem   = (state_reg == ST_COST) && (cnt_reg == STEP_REM);
        ctrl.step_mul_a = (state_reg == ST_COST) && (cnt_reg == STEP_MUL_A);
        ctrl.step_mul_b = (state_reg == ST_COST) && (cnt_reg == STEP_MUL_B);
        ctrl.step_sum   = (state_reg == ST_COST) && (cnt_reg == STEP_SUM);
        ctrl.step_acc   = (state_reg == ST_COST) && (cnt_reg == STEP_ACC);
        ctrl.clear      = load_out;
        // A write pays only for remote keys; a read pays for both kinds.
        ctrl.weight_a   = q_is_write_reg ? 16'd0 : local_read_weight_reg;
        ctrl.weight_b   = q_is_write_reg ? remote_write_weight_reg : remote_read_weight_reg;
        ctrl.eff_nodes  = eff_nodes;
    end

    // The row of node cells. The running minimum enters empty at cell 0 and passes through
    // the token register of every cell on its way out of the last cell.
    assign tok[0] = '0;

    for (genvar n = 0; n < MAX_NODES; n++) begin : g_cell
        mcns_node_cell #(
            .NODE_ID         (n),
            .RANGES_PER_NODE (RANGES_PER_NODE),
            .KEY_BITS        (KEY_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .tok_in  (tok[n]),
            .tok_out (tok[n+1])
        );
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg.best_node      <= 4'(tok[MAX_NODES].node);
            m_data_reg.best_cost      <= tok[MAX_NODES].cost;
            m_data_reg.cost_saturated <= tok[MAX_NODES].sat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: tb/sv/min_cost_node_selector_core_tb.sv
// Self-checking testbench for the minimum-cost node selector core.
module min_cost_node_selector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES          = 16;
    localparam int SLOTS_PER_NODE = 8;
    localparam int RANGE_COUNT    = NODES * SLOTS_PER_NODE;
    localparam int ITEMS_PER_PHASE = 215;
    // The quiet time after the last result is more than enough for the core to finish any trailing query.
    localparam int DRAIN_CYCLES   = 64;
    localparam int CYCLE_LIMIT    = 500000;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    // One row of the directed plan. A row either moves one input item or writes one
    // register. Rows whose result is obvious carry it typed in; the rest are predicted.
    typedef struct {
        row_kind_t                      kind;
        mcns_pkg::in_item_t             item;
        logic [mcns_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [mcns_pkg::CFG_DATA_W-1:0] reg_val;
        bit                             has_golden;
        mcns_pkg::out_item_t            golden;
    } vector_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                s_valid = 1'b0;
    logic                s_ready;
    mcns_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mcns_pkg::out_item_t m_data;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mcns_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mcns_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: the range table, the per-node accumulators and the registers.
    logic [31:0] range_lo   [RANGE_COUNT];
    logic [31:0] range_hi   [RANGE_COUNT];
    logic [7:0]  range_tab  [RANGE_COUNT];
    bit          range_live [RANGE_COUNT];
    logic [mcns_pkg::COST_W-1:0] acc_cost [NODES];
    bit                          acc_sat  [NODES];
    logic [4:0]  cfg_nodes;
    logic [15:0] w_local_rd;
    logic [15:0] w_remote_rd;
    logic [15:0] w_remote_wr;

    // Selections that the core still owes, oldest first.
    mcns_pkg::out_item_t choice_q [$];
    mcns_pkg::out_item_t want_choice;

    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct       = 0;
    int unsigned tb_errors       = 0;
    int unsigned cycles          = 0;

    vector_t plan [$];

    min_cost_node_selector_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Run-away guard. A correct run finishes far below this count.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Puts the predictor back into its reset state. Range bounds and table ids are
    // never read before they are written, so only the in-use bits matter.
    function automatic void reset_model();
        for (int i = 0; i < RANGE_COUNT; i++) begin
            range_lo[i]   = '0;
            range_hi[i]   = '0;
            range_tab[i]  = '0;
            range_live[i] = 1'b0;
        end
        for (int n = 0; n < NODES; n++) begin
            acc_cost[n] = '0;
            acc_sat[n]  = 1'b0;
        end
        cfg_nodes   = 5'd16;
        w_local_rd  = 16'd1;
        w_remote_rd = 16'd10;
        w_remote_wr = 16'd20;
    endfunction

    // Applies one accepted item to the predictor. Returns 1 and fills the selection
    // when the item is a query that closes a request.
    function automatic bit fold_item(input mcns_pkg::in_item_t it,
                                     output mcns_pkg::out_item_t res);
        logic [63:0] qsize;
        logic [63:0] local_keys;
        logic [63:0] remote_keys;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] qcost;
        int unsigned live;
        int unsigned idx;
        int unsigned best;
        res = '0;
        if (it.operation == mcns_pkg::OP_SLOT_WRITE) begin
            idx = int'({it.node, it.slot});
            range_lo[idx]   = it.key_lower;
            range_hi[idx]   = it.key_upper;
            range_tab[idx]  = it.table_id;
            range_live[idx] = it.slot_valid;
            return 1'b0;
        end

        // A count of zero still lets node 0 take part; anything above the node count
        // is clamped to it.
        if (cfg_nodes == 5'd0)
            live = 1;
        else if (cfg_nodes > NODES)
            live = NODES;
        else
            live = cfg_nodes;

        // An upper bound below the lower bound makes an empty query.
        if (it.key_upper < it.key_lower)
            qsize = 64'd0;
        else
            qsize = {32'd0, it.key_upper} - {32'd0, it.key_lower} + 64'd1;

        for (int n = 0; n < live; n++) begin
            local_keys = 64'd0;
            for (int s = 0; s < SLOTS_PER_NODE; s++) begin
                idx = n * SLOTS_PER_NODE + s;
                if (range_live[idx] && range_tab[idx] == it.table_id) begin
                    lo = (range_lo[idx] > it.key_lower) ? range_lo[idx] : it.key_lower;
                    hi = (range_hi[idx] < it.key_upper) ? range_hi[idx] : it.key_upper;
                    if (hi >= lo)
                        local_keys = local_keys + hi - lo + 64'd1;
                end
            end
            // Overlapping ranges can count more local keys than the query holds.
            remote_keys = (local_keys >= qsize) ? 64'd0 : qsize - local_keys;
            if (it.is_write)
                qcost = remote_keys * w_remote_wr;
            else
                qcost = local_keys * w_local_rd + remote_keys * w_remote_rd;
            if (qcost > {16'd0, mcns_pkg::COST_MAX}) begin
                qcost      = {16'd0, mcns_pkg::COST_MAX};
                acc_sat[n] = 1'b1;
            end
            if ({16'd0, acc_cost[n]} + qcost > {16'd0, mcns_pkg::COST_MAX}) begin
                acc_cost[n] = mcns_pkg::COST_MAX;
                acc_sat[n]  = 1'b1;
            end else begin
                acc_cost[n] = acc_cost[n] + qcost[mcns_pkg::COST_W-1:0];
            end
        end
        if (!it.last_query)
            return 1'b0;

        // Strictly-less comparison keeps the lowest node id on ties.
        best = 0;
        for (int n = 1; n < live; n++)
            if (acc_cost[n] < acc_cost[best])
                best = n;
        res.best_node      = 4'(best);
        res.best_cost      = acc_cost[best];
        res.cost_saturated = acc_sat[best];
        for (int n = 0; n < NODES; n++) begin
            acc_cost[n] = '0;
            acc_sat[n]  = 1'b0;
        end
        return 1'b1;
    endfunction

    // Offers one item on the input channel and folds it into the predictor once the
    // transfer completes. Called right after a rising edge. The valid line is left high
    // so that a following item can go out back to back; a random gap lowers it first.
    task automatic send_item(input mcns_pkg::in_item_t it, input bit has_golden,
                             input mcns_pkg::out_item_t golden);
        int unsigned         idle;
        mcns_pkg::out_item_t res;
        idle = 0;
        while ($urandom_range(99) < sender_idle_pct)
            idle++;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (fold_item(it, res))
            choice_q.push_back(has_golden ? golden : res);
    endtask

    // Brings the core to rest: no offered item, every owed selection delivered, and
    // enough quiet cycles for a trailing query that produces no result to finish.
    task automatic settle();
        s_valid <= 1'b0;
        while (choice_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register writes only happen with the core at rest.
    task automatic write_reg(input logic [mcns_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mcns_pkg::CFG_DATA_W-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            mcns_pkg::REG_ACTIVE_NODES:        cfg_nodes   = val[4:0];
            mcns_pkg::REG_LOCAL_READ_WEIGHT:   w_local_rd  = val;
            mcns_pkg::REG_REMOTE_READ_WEIGHT:  w_remote_rd = val;
            mcns_pkg::REG_REMOTE_WRITE_WEIGHT: w_remote_wr = val;
            default: ;
        endcase
    endtask

    // Rows of the directed plan. Slot writes carry set is_write and last_query bits,
    // and queries carry set node, slot and in-use bits, which the core must ignore.
    function automatic vector_t slot_row(input logic [3:0] node, input logic [2:0] slot,
                                         input logic [7:0] tab, input logic [31:0] lo,
                                         input logic [31:0] hi, input bit in_use);
        vector_t v;
        v            = '{kind: ROW_ITEM, default: '0};
        v.kind       = ROW_ITEM;
        v.item       = '0;
        v.item.operation  = mcns_pkg::OP_SLOT_WRITE;
        v.item.node       = node;
        v.item.slot       = slot;
        v.item.table_id   = tab;
        v.item.key_lower  = lo;
        v.item.key_upper  = hi;
        v.item.slot_valid = in_use;
        v.item.is_write   = 1'b1;
        v.item.last_query = 1'b1;
        return v;
    endfunction

    function automatic vector_t query_row(input logic [7:0] tab, input logic [31:0] lo,
                                          input logic [31:0] hi, input bit wr, input bit last,
                                          input bit has_golden,
                                          input mcns_pkg::out_item_t golden);
        vector_t v;
        v            = '{kind: ROW_ITEM, default: '0};
        v.kind       = ROW_ITEM;
        v.item       = '0;
        v.item.operation  = mcns_pkg::OP_QUERY;
        v.item.node       = 4'hF;
        v.item.slot       = 3'h7;
        v.item.slot_valid = 1'b1;
        v.item.table_id   = tab;
        v.item.key_lower  = lo;
        v.item.key_upper  = hi;
        v.item.is_write   = wr;
        v.item.last_query = last;
        v.has_golden      = has_golden;
        v.golden          = golden;
        return v;
    endfunction

    function automatic vector_t reg_row(input logic [mcns_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [mcns_pkg::CFG_DATA_W-1:0] val);
        vector_t v;
        v         = '{kind: ROW_REG, default: '0};
        v.kind    = ROW_REG;
        v.item    = '0;
        v.reg_idx = idx;
        v.reg_val = val;
        return v;
    endfunction

    // Random item. Most keys fall in a narrow window so that queries and ranges overlap
    // often, and most table ids come from a handful of values so that they match.
    // The rest use the full width of every field.
    function automatic mcns_pkg::in_item_t random_item();
        mcns_pkg::in_item_t it;
        logic [31:0]        base;
        it           = '0;
        it.operation = ($urandom_range(99) < 30) ? mcns_pkg::OP_SLOT_WRITE : mcns_pkg::OP_QUERY;
        it.node      = 4'($urandom_range(15));
        it.slot      = 3'($urandom_range(7));
        it.table_id  = ($urandom_range(3) != 0) ? 8'($urandom_range(3)) : 8'($urandom);
        if ($urandom_range(4) != 0) begin
            base         = 32'($urandom_range(4095));
            it.key_lower = base;
            it.key_upper = base + 32'($urandom_range(2047));
        end else begin
            it.key_lower = $urandom;
            it.key_upper = $urandom;
        end
        // Swapped bounds give an empty query or an empty range.
        if ($urandom_range(9) == 0)
            {it.key_lower, it.key_upper} = {it.key_upper, it.key_lower};
        it.slot_valid = ($urandom_range(4) != 0);
        it.is_write   = 1'($urandom_range(1));
        it.last_query = ($urandom_range(3) == 0);
        return it;
    endfunction

    // Result side: random back-pressure, and every completed transfer is compared field
    // by field with the oldest owed selection. Values are sampled at the edge, before
    // any of this edge's updates land.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
            if (m_valid && m_ready) begin
                if (choice_q.size() == 0) begin
                    $display("%0t: unexpected result node=%0d cost=%0h sat=%0b", $realtime,
                             m_data.best_node, m_data.best_cost, m_data.cost_saturated);
                    tb_errors++;
                end else begin
                    want_choice = choice_q.pop_front();
                    if (m_data.best_node !== want_choice.best_node) begin
                        $display("%0t: best_node expected %0d actual %0d", $realtime,
                                 want_choice.best_node, m_data.best_node);
                        tb_errors++;
                    end
                    if (m_data.best_cost !== want_choice.best_cost) begin
                        $display("%0t: best_cost expected %0h actual %0h", $realtime,
                                 want_choice.best_cost, m_data.best_cost);
                        tb_errors++;
                    end
                    if (m_data.cost_saturated !== want_choice.cost_saturated) begin
                        $display("%0t: cost_saturated expected %0b actual %0b", $realtime,
                                 want_choice.cost_saturated, m_data.cost_saturated);
                        tb_errors++;
                    end
                end
            end
        end
    end

    // Main sequence: reset, range table fill, directed plan, then four random phases
    // with different register settings and different idling on each channel.
    initial begin
        mcns_pkg::out_item_t g;
        mcns_pkg::out_item_t none;
        mcns_pkg::in_item_t  fill;
        logic [15:0]         cfg_set [4];
        none = '0;
        reset_model();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load every range slot once, not in use, so that no slot is ever read before
        // it has been written. This doubles as the case of a slot write that clears.
        for (int i = 0; i < RANGE_COUNT; i++) begin
            fill           = '0;
            fill.operation = mcns_pkg::OP_SLOT_WRITE;
            fill.node      = 4'(i / SLOTS_PER_NODE);
            fill.slot      = 3'(i % SLOTS_PER_NODE);
            send_item(fill, 1'b0, none);
        end

        // Right after reset no range is in use: ten remote reads at weight 10 per node.
        g = '{best_node: 4'd0, best_cost: 48'd100, cost_saturated: 1'b0};
        plan.push_back(query_row(8'd0, 32'd0, 32'd9, 1'b0, 1'b1, 1'b1, g));
        // Two overlapping ranges on node 3: local keys exceed the query size.
        plan.push_back(slot_row(4'd3, 3'd0, 8'd7, 32'd100, 32'd199, 1'b1));
        plan.push_back(slot_row(4'd3, 3'd1, 8'd7, 32'd150, 32'd249, 1'b1));
        plan.push_back(query_row(8'd7, 32'd100, 32'd199, 1'b0, 1'b1, 1'b0, none));
        // A write query followed by an empty query that closes the request.
        plan.push_back(query_row(8'd7, 32'd100, 32'd299, 1'b1, 1'b0, 1'b0, none));
        plan.push_back(query_row(8'd7, 32'd5, 32'd4, 1'b0, 1'b1, 1'b0, none));
        // Full key range on the last node and slot, plus an empty range beside it.
        plan.push_back(slot_row(4'd15, 3'd7, 8'd255, 32'd0, 32'hFFFF_FFFF, 1'b1));
        plan.push_back(slot_row(4'd15, 3'd6, 8'd255, 32'd10, 32'd5, 1'b1));
        g = '{best_node: 4'd15, best_cost: 48'h0001_0000_0000, cost_saturated: 1'b0};
        plan.push_back(query_row(8'd255, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, g));
        plan.push_back(slot_row(4'd3, 3'd1, 8'd7, 32'd0, 32'd0, 1'b0));
        // A node count of zero behaves as one node.
        plan.push_back(reg_row(mcns_pkg::REG_ACTIVE_NODES, 16'd0));
        g = '{best_node: 4'd0, best_cost: 48'h000A_0000_0000, cost_saturated: 1'b0};
        plan.push_back(query_row(8'd255, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, g));
        // A count above the node total behaves as all nodes; all weights at maximum.
        plan.push_back(reg_row(mcns_pkg::REG_ACTIVE_NODES, 16'd31));
        plan.push_back(reg_row(mcns_pkg::REG_LOCAL_READ_WEIGHT, 16'hFFFF));
        plan.push_back(reg_row(mcns_pkg::REG_REMOTE_READ_WEIGHT, 16'hFFFF));
        plan.push_back(reg_row(mcns_pkg::REG_REMOTE_WRITE_WEIGHT, 16'hFFFF));
        // Two full-range ranges on node 0 saturate a single query's cost there; the
        // second query saturates every accumulator, so node 0 wins the tie.
        plan.push_back(slot_row(4'd0, 3'd0, 8'd9, 32'd0, 32'hFFFF_FFFF, 1'b1));
        plan.push_back(slot_row(4'd0, 3'd1, 8'd9, 32'd0, 32'hFFFF_FFFF, 1'b1));
        plan.push_back(query_row(8'd9, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, none));
        g = '{best_node: 4'd0, best_cost: mcns_pkg::COST_MAX, cost_saturated: 1'b1};
        plan.push_back(query_row(8'd9, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, g));
        // A write fully covered by local ranges costs nothing.
        g = '{best_node: 4'd0, best_cost: 48'd0, cost_saturated: 1'b0};
        plan.push_back(query_row(8'd9, 32'd0, 32'd0, 1'b1, 1'b1, 1'b1, g));
        // Zero weights make every cost zero.
        plan.push_back(reg_row(mcns_pkg::REG_LOCAL_READ_WEIGHT, 16'd0));
        plan.push_back(reg_row(mcns_pkg::REG_REMOTE_READ_WEIGHT, 16'd0));
        plan.push_back(reg_row(mcns_pkg::REG_REMOTE_WRITE_WEIGHT, 16'd0));
        plan.push_back(query_row(8'd9, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, g));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_item(plan[i].item, plan[i].has_golden, plan[i].golden);
        end

        // Random phases: no idling, an idle sender, a stalling receiver, then both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: cfg_set = '{16'd16, 16'd1, 16'd10, 16'd20};
                1: cfg_set = '{16'($urandom_range(1, 16)), 16'($urandom), 16'($urandom),
                               16'($urandom)};
                2: cfg_set = '{16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                default: cfg_set = '{16'($urandom_range(31)), 16'd0, 16'($urandom),
                                     16'($urandom)};
            endcase
            write_reg(mcns_pkg::REG_ACTIVE_NODES, cfg_set[0]);
            write_reg(mcns_pkg::REG_LOCAL_READ_WEIGHT, cfg_set[1]);
            write_reg(mcns_pkg::REG_REMOTE_READ_WEIGHT, cfg_set[2]);
            write_reg(mcns_pkg::REG_REMOTE_WRITE_WEIGHT, cfg_set[3]);
            case (ph)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 67; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 67; end
                default: begin sender_idle_pct = 21; stall_pct = 21; end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_item(random_item(), 1'b0, none);
        end

        // Wait for every owed selection and a quiet tail, then give the verdict.
        settle();
        if (tb_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mcns_pkg.sv
rtl/core/mcns_ram.sv
rtl/core/mcns_node_cell.sv
rtl/core/min_cost_node_selector_core.sv
tb/sv/min_cost_node_selector_core_tb.sv
